@@ src/lpht_pkg.sv @@
// Shared constants, types and codes for the linear-probing hash table.
`default_nettype none
package lpht_pkg;

	// Table geometry; CAPACITY is a power of two.
	localparam int CAPACITY   = 64;
	localparam int CAP_LOG2   = $clog2(CAPACITY);
	localparam int IDX_W      = CAP_LOG2;
	localparam int STEP_W     = CAP_LOG2 + 1;
	localparam int COUNT_W    = 7;

	// Key and hash.
	localparam int KEY_BYTES  = 8;
	localparam int KEY_W      = 64;
	localparam int BIDX_W     = 3;
	localparam int LEN_W      = 4;
	localparam int HASH_W     = 32;
	localparam int VAL_W      = 32;
	localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
	localparam int HASH_SHIFT = 5;

	// Command and result fields.
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;

	// Configuration port.
	localparam int CFG_W      = 3;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;
	localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 3'd6;
	localparam logic REG_SIZE_LOG2 = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET = 2'd0,
		CMD_GET = 2'd1,
		CMD_DEL = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HASH,
		S_READ,
		S_EVAL,
		S_COMMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic hash_step;
		logic probe_start;
		logic rd_issue;
		logic probe_eval;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic hash_done;
		logic is_nop;
		logic probe_last;
		logic out_free;
	} dp_stat_t;

	// One slot word in the table memory; live low marks a tombstone.
	typedef struct packed {
		logic              live;
		logic [HASH_W-1:0] hash;
		logic [KEY_W-1:0]  key;
		logic [VAL_W-1:0]  value;
	} slot_t;

endpackage
`default_nettype wire

@@ src/lpht_ctrl.sv @@
// Sequencer for the hash table: hash, probe loop, commit.
`default_nettype none
module lpht_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lpht_pkg::dp_stat_t   stat,
	output lpht_pkg::ctrl_cmd_t  ctl
);
	import lpht_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_HASH;
			end
			S_HASH: begin
				if (stat.hash_done) state_d = stat.is_nop ? S_COMMIT : S_READ;
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = stat.probe_last ? S_COMMIT : S_READ;
			end
			S_COMMIT: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			S_HASH: begin
				ctl.hash_step   = !stat.hash_done;
				ctl.probe_start = stat.hash_done && !stat.is_nop;
			end
			S_READ: begin
				ctl.rd_issue = 1'b1;
			end
			S_EVAL: begin
				ctl.probe_eval = 1'b1;
			end
			S_COMMIT: begin
				ctl.commit = stat.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ src/lpht_dp.sv @@
// Datapath: key capture, djb2 hash, slot memory, probe registers, result register.
`default_nettype none
module lpht_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lpht_pkg::ctrl_cmd_t            ctl,
	output lpht_pkg::dp_stat_t             stat,
	input  logic [lpht_pkg::CFG_W-1:0]     size_log2,
	input  logic [lpht_pkg::CMD_W-1:0]     command,
	input  logic [lpht_pkg::KEY_W-1:0]     key,
	input  logic [lpht_pkg::VAL_W-1:0]     value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lpht_pkg::STATUS_W-1:0]  status,
	output logic [lpht_pkg::VAL_W-1:0]     read_value,
	output logic [lpht_pkg::COUNT_W-1:0]   entry_count
);
	import lpht_pkg::*;

	// Slot memory and per-slot written flags (flag clear = empty slot).
	slot_t               mem [CAPACITY];
	logic [CAPACITY-1:0] vld_q;

	// Command context.
	cmd_t              cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [VAL_W-1:0]  value_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  idx_q;
	logic [HASH_W-1:0] hash_q;

	// Probe state.
	logic [IDX_W-1:0]  p_q;
	logic [STEP_W-1:0] i_q;
	slot_t             rd_slot_q;
	logic              rd_vld_q;
	logic              found_q;
	logic              have_free_q;
	logic [IDX_W-1:0]  hit_q;
	logic [IDX_W-1:0]  free_q;
	logic [VAL_W-1:0]  hit_val_q;

	// Count and result register.
	logic [COUNT_W-1:0]  count_q;
	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [VAL_W-1:0]    read_value_q;
	logic [COUNT_W-1:0]  entry_q;

	// Key canonicalization: drop the first zero byte and everything after it.
	logic [KEY_BYTES:0] keep;
	logic [KEY_W-1:0]   canon_key;
	logic [LEN_W-1:0]   canon_len;

	always_comb begin
		keep[0]   = 1'b1;
		canon_key = '0;
		canon_len = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			keep[b+1] = keep[b] && (key[8*b +: 8] != 8'd0);
			if (keep[b+1]) canon_key[8*b +: 8] = key[8*b +: 8];
			canon_len = canon_len + LEN_W'(keep[b+1]);
		end
	end

	// One key byte per cycle: h = h*33 + byte.
	logic [7:0]        byte_v;
	logic [HASH_W-1:0] hash_next;

	assign byte_v    = key_q[8*idx_q[BIDX_W-1:0] +: 8];
	assign hash_next = (hash_q << HASH_SHIFT) + hash_q + HASH_W'(byte_v);

	// Capacity in use, saturated to the table size.
	logic [STEP_W-1:0] cap;
	logic [IDX_W-1:0]  mask;

	always_comb begin
		if (int'(size_log2) > CAP_LOG2) begin
			cap = STEP_W'(CAPACITY);
		end else begin
			cap = STEP_W'(1) << size_log2;
		end
	end
	assign mask = IDX_W'(cap - STEP_W'(1));

	// Probe evaluation on the registered slot word.
	logic              used;
	logic              match;
	logic [STEP_W-1:0] i_next;

	assign used   = rd_vld_q && rd_slot_q.live;
	assign match  = used && (rd_slot_q.hash == hash_q) && (rd_slot_q.key == key_q);
	assign i_next = i_q + STEP_W'(1);

	// Commit decision.
	logic               wr_req;
	logic [IDX_W-1:0]   wr_addr;
	slot_t              wr_slot;
	logic               set_vld;
	logic [COUNT_W-1:0] next_count;
	status_t            res_status;
	logic [VAL_W-1:0]   res_val;

	always_comb begin
		wr_req     = 1'b0;
		wr_addr    = hit_q;
		wr_slot    = '{live: 1'b1, hash: hash_q, key: key_q, value: value_q};
		set_vld    = 1'b0;
		next_count = count_q;
		res_status = ST_OK;
		res_val    = '0;
		unique case (cmd_q)
			CMD_SET: begin
				if (found_q) begin
					wr_req = 1'b1;
				end else if (have_free_q) begin
					wr_req     = 1'b1;
					wr_addr    = free_q;
					set_vld    = 1'b1;
					next_count = count_q + COUNT_W'(1);
				end else begin
					res_status = ST_FULL;
				end
			end
			CMD_GET: begin
				if (found_q) res_val = hit_val_q;
				else res_status = ST_NOT_FOUND;
			end
			CMD_DEL: begin
				if (found_q) begin
					wr_req       = 1'b1;
					wr_slot.live = 1'b0;
					if (count_q != '0) next_count = count_q - COUNT_W'(1);
				end else begin
					res_status = ST_NOT_FOUND;
				end
			end
			CMD_NOP: begin
				res_status = ST_OK;
			end
			default: begin
				res_status = ST_OK;
			end
		endcase
	end

	// Slot memory: one read port, one write port, registered read.
	always_ff @(posedge clk) begin
		if (ctl.rd_issue) rd_slot_q <= mem[p_q];
		if (ctl.commit && wr_req) mem[wr_addr] <= wr_slot;
	end

	// Command context and probe registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q       <= cmd_t'(command);
			key_q       <= canon_key;
			value_q     <= value;
			len_q       <= canon_len;
			idx_q       <= '0;
			hash_q      <= HASH_SEED;
			found_q     <= 1'b0;
			have_free_q <= 1'b0;
		end
		if (ctl.hash_step) begin
			hash_q <= hash_next;
			idx_q  <= idx_q + LEN_W'(1);
		end
		if (ctl.probe_start) begin
			p_q <= hash_q[IDX_W-1:0] & mask;
			i_q <= '0;
		end
		if (ctl.rd_issue) rd_vld_q <= vld_q[p_q];
		if (ctl.probe_eval) begin
			p_q <= (p_q + IDX_W'(1)) & mask;
			i_q <= i_next;
			if (match) begin
				found_q   <= 1'b1;
				hit_q     <= p_q;
				hit_val_q <= rd_slot_q.value;
			end else if (!used && !have_free_q) begin
				have_free_q <= 1'b1;
				free_q      <= p_q;
			end
		end
		if (ctl.commit) begin
			status_q     <= res_status;
			read_value_q <= res_val;
			entry_q      <= next_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
				count_q     <= next_count;
				if (set_vld) vld_q[free_q] <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.hash_done  = (idx_q == len_q);
	assign stat.is_nop     = (cmd_q == CMD_NOP);
	assign stat.probe_last = match || !rd_vld_q || (i_next == cap);
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(CAPACITY))
		else $error("occupied count above capacity");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || !out_stall))
		else $error("commit over a result still waiting");

	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.probe_eval |-> (i_q < cap))
		else $error("probe visited more slots than the capacity");

	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && (res_status != ST_OK)) |=> $stable(count_q))
		else $error("failed command changed the occupied count");

endmodule
`default_nettype wire

@@ src/linear_probe_hash_table.sv @@
// Top level of the linear-probing key/value table: config register and module wiring.
`default_nettype none
// Open-addressing key/value table with 64 slots. Each input transaction carries a
// command (set, get, delete; code 3 does nothing), a key of up to eight bytes
// (first byte in bits 7..0, ending at the first zero byte) and a value. Each one
// yields exactly one output transaction with status (ok, not found, full), the value
// read by a get (zero otherwise) and the number of occupied slots afterwards. The
// home slot is the djb2 hash of the key masked to 2**size_log2 slots (capped at 64);
// probing walks forward and wraps, passing over tombstones left by deletes, and a
// set reuses the first free or tombstoned slot it passed. Timing: one transaction is
// in flight at a time. The hash takes one key byte per cycle, and each probed slot
// is a registered read of the slot memory followed by a compare. A finished result
// sits in an output register, so the block is free for the next command as long as
// that result is taken before the next commit. size_log2 sits at byte address 0 of
// the APB port, resets to 6, and must be written only while no transaction is in
// flight; entries beyond a reduced capacity are kept and still counted but cannot be
// reached. Reset empties the table at once; no clearing pass is needed.
module linear_probe_hash_table (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [lpht_pkg::CMD_W-1:0]     command,
	input  logic [lpht_pkg::KEY_W-1:0]     key,
	input  logic [lpht_pkg::VAL_W-1:0]     value,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [lpht_pkg::STATUS_W-1:0]  status,
	output logic [lpht_pkg::VAL_W-1:0]     read_value,
	output logic [lpht_pkg::COUNT_W-1:0]   entry_count,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [lpht_pkg::PADDR_W-1:0]   paddr,
	input  logic [lpht_pkg::PDATA_W-1:0]   pwdata,
	output logic [lpht_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import lpht_pkg::*;

	logic [CFG_W-1:0] size_log2_q;
	logic             reg_hit;
	ctrl_cmd_t        ctl;
	dp_stat_t         stat;

	// Only one register; it is selected when address bit 2 is clear, low bits are ignored.
	assign reg_hit = (paddr[2] == REG_SIZE_LOG2);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_log2_q <= SIZE_LOG2_RST;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			size_log2_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_hit) prdata = PDATA_W'(size_log2_q);
	end

	// Sequencer: accept, hash, probe loop, commit.
	lpht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl)
	);

	// Slot memory, hash unit, probe registers and the result register.
	lpht_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.size_log2   (size_log2_q),
		.command     (command),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_value  (read_value),
		.entry_count (entry_count)
	);

endmodule
`default_nettype wire
